/* design/shs_pkg.sv */
// Shared types, constants and round functions for the SHA-256 stream hasher.
`timescale 1ns / 1ps

package shs_pkg;

	typedef logic [31:0] word_t;

	// Eight working or chaining words, index 0 is a / H0
	typedef logic [7:0][31:0] hash_t;

	localparam hash_t HASH_IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	// Request codes carried by func
	localparam logic [1:0] FUNC_ABSORB = 2'd0;
	localparam logic [1:0] FUNC_FINISH = 2'd1;
	localparam logic [1:0] FUNC_CLOSE  = 2'd2;

	// First padding byte
	localparam logic [7:0] PAD_MARK = 8'h80;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_OUT
	} st_t;

	// Control from the sequencer to the message schedule
	typedef struct packed {
		logic       shift;
		logic [7:0] din;
		logic       step;
	} sched_ctrl_t;

	// Control from the sequencer to the round unit
	typedef struct packed {
		logic load;
		logic step;
	} rnd_ctrl_t;

	function automatic word_t rotr(input word_t x, input int unsigned r);
		rotr = (x >> r) | (x << (32 - r));
	endfunction

	function automatic word_t small_sig0(input word_t x);
		small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sig1(input word_t x);
		small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t big_sig0(input word_t x);
		big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sig1(input word_t x);
		big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t ch_f(input word_t e, input word_t f, input word_t g);
		ch_f = (e & f) ^ (~e & g);
	endfunction

	function automatic word_t maj_f(input word_t a, input word_t b, input word_t c);
		maj_f = (a & b) ^ (a & c) ^ (b & c);
	endfunction

	// Round constants
	function automatic word_t round_k(input logic [5:0] idx);
		case (idx)
			6'd0:  round_k = 32'h428a2f98;
			6'd1:  round_k = 32'h71374491;
			6'd2:  round_k = 32'hb5c0fbcf;
			6'd3:  round_k = 32'he9b5dba5;
			6'd4:  round_k = 32'h3956c25b;
			6'd5:  round_k = 32'h59f111f1;
			6'd6:  round_k = 32'h923f82a4;
			6'd7:  round_k = 32'hab1c5ed5;
			6'd8:  round_k = 32'hd807aa98;
			6'd9:  round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be;
			6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74;
			6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7;
			6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1;
			6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6;
			6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f;
			6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc;
			6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152;
			6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8;
			6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3;
			6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351;
			6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85;
			6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc;
			6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354;
			6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e;
			6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1;
			6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70;
			6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819;
			6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585;
			6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116;
			6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c;
			6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3;
			6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f;
			6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee;
			6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814;
			6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa;
			6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7;
			6'd63: round_k = 32'hc67178f2;
			default: round_k = 32'h00000000;
		endcase
	endfunction

endpackage

/* design/sha256_stream_hasher_unit.sv */
// Top level of the SHA-256 stream hasher: sequencer, chaining words and digest output.
`timescale 1ns / 1ps

// SHA-256 over a byte stream. Each accepted word brings one message byte (func 0),
// one byte then finish (func 1) or a bare finish (func 2); func 3 is taken and ignored.
// Every 64th byte starts a compression (one round per cycle in a single shared round
// unit) and then a fold into the chain, during which ready is low. Finishing feeds the
// 9 to 72 pad and length bytes through the same byte path, one per cycle outside the
// one or two compressions that they start, then presents the digest as eight 32-bit
// words, index 0 first, one per accepted output word. After the eighth word the hash
// returns to its initial value and ready rises again.
module sha256_stream_hasher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [7:0]  data_byte,
	input  logic [1:0]  func,
	output logic        digest_valid,
	input  logic        digest_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import shs_pkg::*;

	st_t         st_q;
	st_t         st_nxt;
	hash_t       chain_q;
	logic [5:0]  fill_q;
	logic [63:0] bitlen_q;
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic        fin_q;
	logic        len_q;
	logic        long_q;
	logic        first_q;

	logic        acc;
	logic        absorb;
	logic        finish;
	logic        blk_full;
	logic        len_pos;
	logic [63:0] len_sh;
	logic [7:0]  pad_byte;
	sched_ctrl_t sc;
	rnd_ctrl_t   rc;
	word_t       w_cur;
	hash_t       v;

	assign acc    = valid && ready;
	assign absorb = acc && (func inside {FUNC_ABSORB, FUNC_FINISH});
	assign finish = acc && (func inside {FUNC_FINISH, FUNC_CLOSE});

	// Pick the padding byte: marker, length byte or zero
	assign len_pos  = (&fill_q[5:3]) && !first_q && !long_q;
	assign len_sh   = bitlen_q >> {~fill_q[2:0], 3'b000};
	assign pad_byte = first_q ? PAD_MARK : (len_pos ? len_sh[7:0] : 8'h00);

	assign blk_full = sc.shift && (&fill_q);

	// Drive handshakes and unit controls
	always_comb begin
		ready        = (st_q == ST_IDLE);
		digest_valid = (st_q == ST_OUT);
		sc.shift     = absorb || (st_q == ST_PAD);
		sc.din       = (st_q == ST_PAD) ? pad_byte : data_byte;
		sc.step      = (st_q == ST_ROUND);
		rc.step      = (st_q == ST_ROUND);
		rc.load      = blk_full;
	end

	// Next state
	always_comb begin
		st_nxt = st_q;
		case (st_q)
			ST_IDLE: begin
				if (blk_full) begin
					st_nxt = ST_ROUND;
				end else if (finish) begin
					st_nxt = ST_PAD;
				end
			end
			ST_ROUND: begin
				if (&rnd_q) begin
					st_nxt = ST_ADD;
				end
			end
			ST_ADD: begin
				if (fin_q && len_q) begin
					st_nxt = ST_OUT;
				end else if (fin_q) begin
					st_nxt = ST_PAD;
				end else begin
					st_nxt = ST_IDLE;
				end
			end
			ST_PAD: begin
				if (blk_full) begin
					st_nxt = ST_ROUND;
				end
			end
			ST_OUT: begin
				if (digest_ready && (&oidx_q)) begin
					st_nxt = ST_IDLE;
				end
			end
			default: st_nxt = ST_IDLE;
		endcase
	end

	// Hold state, counters, flags and chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			chain_q  <= HASH_IV;
			fill_q   <= '0;
			bitlen_q <= '0;
			rnd_q    <= '0;
			oidx_q   <= '0;
			fin_q    <= 1'b0;
			len_q    <= 1'b0;
			long_q   <= 1'b0;
			first_q  <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (absorb) begin
				bitlen_q <= bitlen_q + 64'd8;
			end
			if (sc.shift) begin
				fill_q <= fill_q + 6'd1;
			end
			if (finish) begin
				fin_q   <= 1'b1;
				first_q <= 1'b1;
			end
			if (st_q == ST_PAD) begin
				first_q <= 1'b0;
				if (blk_full) begin
					long_q <= 1'b0;
				end else if (first_q) begin
					long_q <= &fill_q[5:3];
				end
				if (len_pos) begin
					len_q <= 1'b1;
				end
			end
			if (st_q == ST_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end
			// Fold the working words into the chain
			if (st_q == ST_ADD) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + v[i];
				end
			end
			// Advance the digest index; restart after the last word
			if ((st_q == ST_OUT) && digest_ready) begin
				oidx_q <= oidx_q + 3'd1;
				if (&oidx_q) begin
					chain_q  <= HASH_IV;
					fill_q   <= '0;
					bitlen_q <= '0;
					fin_q    <= 1'b0;
					len_q    <= 1'b0;
					long_q   <= 1'b0;
					first_q  <= 1'b0;
				end
			end
		end
	end

	assign digest_word = chain_q[oidx_q];
	assign word_index  = oidx_q;
	assign last_word   = &oidx_q;

	shs_sched u_sched (
		.clk   (clk),
		.ctrl  (sc),
		.w_cur (w_cur)
	);

	shs_round u_round (
		.clk  (clk),
		.ctrl (rc),
		.init (chain_q),
		.k    (round_k(rnd_q)),
		.w    (w_cur),
		.v    (v)
	);

endmodule

/* design/shs_sched.sv */
// Block buffer and message schedule: a 16-word window that takes bytes or expands words.
`timescale 1ns / 1ps

module shs_sched (
	input  logic                clk,
	input  shs_pkg::sched_ctrl_t ctrl,
	output shs_pkg::word_t      w_cur
);
	import shs_pkg::*;

	word_t win_q [16];
	word_t w_new;

	// Next schedule word from the window taps
	assign w_new = win_q[0] + small_sig0(win_q[1]) + win_q[9] + small_sig1(win_q[14]);
	assign w_cur = win_q[0];

	// Shift a byte in at the tail, or advance the window by one word
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= {win_q[i][23:0], win_q[i + 1][31:24]};
			end
			win_q[15] <= {win_q[15][23:0], ctrl.din};
		end else if (ctrl.step) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= w_new;
		end
	end

endmodule

/* design/shs_round.sv */
// Compression round unit: eight working words updated one round per cycle while step is high.
`timescale 1ns / 1ps

module shs_round (
	input  logic              clk,
	input  shs_pkg::rnd_ctrl_t ctrl,
	input  shs_pkg::hash_t    init,
	input  shs_pkg::word_t    k,
	input  shs_pkg::word_t    w,
	output shs_pkg::hash_t    v
);
	import shs_pkg::*;

	hash_t v_q;
	hash_t v_nxt;
	word_t t1;
	word_t t2;

	// One SHA-256 round
	always_comb begin
		t1 = v_q[7] + big_sig1(v_q[4]) + ch_f(v_q[4], v_q[5], v_q[6]) + k + w;
		t2 = big_sig0(v_q[0]) + maj_f(v_q[0], v_q[1], v_q[2]);
		v_nxt[0] = t1 + t2;
		v_nxt[1] = v_q[0];
		v_nxt[2] = v_q[1];
		v_nxt[3] = v_q[2];
		v_nxt[4] = v_q[3] + t1;
		v_nxt[5] = v_q[4];
		v_nxt[6] = v_q[5];
		v_nxt[7] = v_q[6];
	end

	// Load from the chain at block start, then advance each round
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			v_q <= init;
		end else if (ctrl.step) begin
			v_q <= v_nxt;
		end
	end

	assign v = v_q;

endmodule
